// ----- hw/rtl/chs_pkg.sv -----
package chs_pkg;

  // Width of the octant ratio and of the trig values, Q30 with headroom for 1.0.
  localparam int T_W = 31;
  // Steps of the square root: radicand up to 2^32 needs seventeen bit pairs.
  localparam int SQ_STEPS = 17;
  localparam int SQ_W = 34;

  localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [T_W-1:0] SIN_A1 = 31'd843314857;
  localparam logic [T_W-1:0] SIN_A3 = 31'd86699835;
  localparam logic [T_W-1:0] SIN_A5 = 31'd2674041;
  localparam logic [T_W-1:0] SIN_A7 = 31'd39273;
  localparam logic [T_W-1:0] COS_B2 = 31'd331168970;
  localparam logic [T_W-1:0] COS_B4 = 31'd17023472;
  localparam logic [T_W-1:0] COS_B6 = 31'd350032;
  localparam logic [T_W-1:0] COS_B8 = 31'd3856;
  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

  localparam logic [1:0] REG_RED = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE = 2'd2;

  typedef struct packed {
    logic center;
    logic axis_x;
    logic axis_neg;
    logic q_neg;
  } chs_flags_t;

  function automatic logic [T_W-1:0] mul30(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
    logic [2*T_W-1:0] prod;
    prod = a * b;
    return prod[T_W+29:30];
  endfunction

  // Rounded multiply by 1/pi, kept to fifteen bits.
  function automatic logic [14:0] div_pi16(input logic [15:0] v);
    logic [47:0] prod;
    prod = {16'd0, v} * {16'd0, INV_PI_Q32} + 48'h0000_8000_0000;
    return prod[46:32];
  endfunction

  // Two's complement pattern from sign and magnitude, saturated.
  function automatic logic [15:0] pack_signed(input logic neg, input logic [16:0] mag);
    logic [16:0] m;
    logic [16:0] d;
    if (neg) begin
      m = (mag > 17'h08000) ? 17'h08000 : mag;
      d = 17'h10000 - m;
    end else begin
      m = (mag > 17'h07fff) ? 17'h07fff : mag;
      d = m;
    end
    return d[15:0];
  endfunction

endpackage

// ----- hw/rtl/cosine_hemisphere_sampler.sv -----
// Cosine-weighted hemisphere sampler. Each item is a pair of uniform samples;
// the block maps it onto the unit disc with the concentric mapping and lifts
// it to the hemisphere, returning the direction, its density z/pi and the
// three albedo registers divided by pi. One item enters per clock unless a
// stall on the output holds the whole pipeline in place. Most stages are the
// one-bit-per-stage ratio divider (32 stages) and the square-root pipeline
// (18 stages). The user must write the albedo registers only while no item is
// in flight, which the block does not enforce; scaled values follow next cycle.
module cosine_hemisphere_sampler #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] rand_first,
  input  logic [15:0] rand_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic [14:0] dir_z,
  output logic [14:0] density,
  output logic [14:0] energy_red,
  output logic [14:0] energy_green,
  output logic [14:0] energy_blue
);

  localparam int SB = SAMPLE_BITS;
  localparam int RW = SB + 1;
  localparam int TW = chs_pkg::T_W;
  localparam int FW = $bits(chs_pkg::chs_flags_t);
  localparam int MW = RW + FW;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration.
  logic [15:0] diffuse_red, diffuse_green, diffuse_blue;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffuse_red <= '0;
      diffuse_green <= '0;
      diffuse_blue <= '0;
      energy_red <= '0;
      energy_green <= '0;
      energy_blue <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          chs_pkg::REG_RED: diffuse_red <= cfg_data;
          chs_pkg::REG_GREEN: diffuse_green <= cfg_data;
          chs_pkg::REG_BLUE: diffuse_blue <= cfg_data;
          default: ;
        endcase
      end
      energy_red <= chs_pkg::div_pi16(diffuse_red);
      energy_green <= chs_pkg::div_pi16(diffuse_green);
      energy_blue <= chs_pkg::div_pi16(diffuse_blue);
    end
  end

  // Stage A: center samples, pick the wedge, radius and the other coordinate.
  logic [SB-1:0] u1, u2;
  logic signed [SB+1:0] sx, sy, rs, qs;
  logic signed [SB+2:0] sxy;
  chs_pkg::chs_flags_t flags_c;

  assign u1 = SB'(rand_first);
  assign u2 = SB'(rand_second);
  assign sx = $signed({1'b0, u1, 1'b0}) - $signed({2'b01, {SB{1'b0}}});
  assign sy = $signed({1'b0, u2, 1'b0}) - $signed({2'b01, {SB{1'b0}}});
  assign sxy = {sx[SB+1], sx} + {sy[SB+1], sy};

  always_comb begin
    flags_c.center = (sx == '0) && (sy == '0);
    if (!sxy[SB+2]) begin
      flags_c.axis_neg = 1'b0;
      if (sx > sy) begin
        rs = sx;
        qs = sy;
        flags_c.axis_x = 1'b1;
      end else begin
        rs = sy;
        qs = sx;
        flags_c.axis_x = 1'b0;
      end
    end else begin
      flags_c.axis_neg = 1'b1;
      if (sx <= sy) begin
        rs = -sx;
        qs = sy;
        flags_c.axis_x = 1'b1;
      end else begin
        rs = -sy;
        qs = sx;
        flags_c.axis_x = 1'b0;
      end
    end
    flags_c.q_neg = qs[SB+1];
  end

  logic                a_valid;
  logic [RW-1:0]       a_r, a_aq;
  chs_pkg::chs_flags_t a_flags;
  logic signed [SB+1:0] aq_s;
  assign aq_s = qs[SB+1] ? -qs : qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= rs[SB:0];
      a_aq <= aq_s[SB:0];
      a_flags <= flags_c;
    end
  end

  // Ratio t = |q| / r in Q30.
  logic          d_valid;
  logic [TW-1:0] d_quot;
  logic [MW-1:0] d_meta;

  chs_div #(.DW(RW), .MW(MW)) u_div (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(a_valid),
    .numer(a_aq),
    .denom(a_r),
    .in_meta({a_r, a_flags}),
    .out_valid(d_valid),
    .quot(d_quot),
    .out_meta(d_meta)
  );

  // Trig pipeline: t^2, three Horner steps, final products.
  logic                p_valid [1:5];
  logic [RW-1:0]       p_r [1:5];
  chs_pkg::chs_flags_t p_flags [1:5];
  logic [TW-1:0]       p_t [1:4];
  logic [TW-1:0]       p_t2 [1:4];
  logic [TW-1:0]       p_sp [2:4];
  logic [TW-1:0]       p_cp [2:4];
  logic [TW-1:0]       sin_v, cos_v;
  logic [TW-1:0]       t_clamp;

  assign t_clamp = (d_quot > chs_pkg::Q30_ONE) ? chs_pkg::Q30_ONE : d_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) begin
        p_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      p_valid[1] <= d_valid;
      for (int k = 2; k <= 5; k++) begin
        p_valid[k] <= p_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[1] <= d_meta[MW-1:FW];
      p_flags[1] <= d_meta[FW-1:0];
      for (int k = 2; k <= 5; k++) begin
        p_r[k] <= p_r[k-1];
        p_flags[k] <= p_flags[k-1];
      end
      p_t[1] <= t_clamp;
      p_t2[1] <= chs_pkg::mul30(t_clamp, t_clamp);
      for (int k = 2; k <= 4; k++) begin
        p_t[k] <= p_t[k-1];
        p_t2[k] <= p_t2[k-1];
      end
      p_sp[2] <= chs_pkg::SIN_A5 - chs_pkg::mul30(p_t2[1], chs_pkg::SIN_A7);
      p_cp[2] <= chs_pkg::COS_B6 - chs_pkg::mul30(p_t2[1], chs_pkg::COS_B8);
      p_sp[3] <= chs_pkg::SIN_A3 - chs_pkg::mul30(p_t2[2], p_sp[2]);
      p_cp[3] <= chs_pkg::COS_B4 - chs_pkg::mul30(p_t2[2], p_cp[2]);
      p_sp[4] <= chs_pkg::SIN_A1 - chs_pkg::mul30(p_t2[3], p_sp[3]);
      p_cp[4] <= chs_pkg::COS_B2 - chs_pkg::mul30(p_t2[3], p_cp[3]);
      sin_v <= chs_pkg::mul30(p_t[4], p_sp[4]);
      cos_v <= chs_pkg::Q30_ONE - chs_pkg::mul30(p_t2[4], p_cp[4]);
    end
  end

  // Scale by the radius to Q1.15, rounded half up.
  localparam int PW = RW + TW;
  logic [PW-1:0] along_p, across_p;
  assign along_p = {{TW{1'b0}}, p_r[5]} * {{RW{1'b0}}, cos_v} + (PW'(1) << (SB + 14));
  assign across_p = {{TW{1'b0}}, p_r[5]} * {{RW{1'b0}}, sin_v} + (PW'(1) << (SB + 14));

  logic                s_valid;
  logic [16:0]         s_along, s_across;
  chs_pkg::chs_flags_t s_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= p_valid[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_along <= along_p[SB+31:SB+15];
      s_across <= across_p[SB+31:SB+15];
      s_flags <= p_flags[5];
    end
  end

  // Place along/across on the axes and pack with saturation.
  logic [16:0] mx, my;
  logic        nx, ny;
  always_comb begin
    if (s_flags.axis_x) begin
      mx = s_along;
      nx = s_flags.axis_neg;
      my = s_across;
      ny = s_flags.q_neg;
    end else begin
      my = s_along;
      ny = s_flags.axis_neg;
      mx = s_across;
      nx = s_flags.q_neg;
    end
    if (s_flags.center) begin
      mx = '0;
      my = '0;
    end
  end

  logic        k_valid;
  logic [15:0] k_ox, k_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (adv) begin
      k_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_ox <= chs_pkg::pack_signed(nx, mx);
      k_oy <= chs_pkg::pack_signed(ny, my);
    end
  end

  // Squares of the rounded components.
  logic [16:0] ax_w, ay_w;
  logic [15:0] ax, ay;
  assign ax_w = k_ox[15] ? (17'h10000 - {1'b0, k_ox}) : {1'b0, k_ox};
  assign ay_w = k_oy[15] ? (17'h10000 - {1'b0, k_oy}) : {1'b0, k_oy};
  assign ax = ax_w[15:0];
  assign ay = ay_w[15:0];

  logic        q_valid;
  logic [15:0] q_ox, q_oy;
  logic [31:0] q_sqx, q_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (adv) begin
      q_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_ox <= k_ox;
      q_oy <= k_oy;
      q_sqx <= ax * ax;
      q_sqy <= ay * ay;
    end
  end

  // Radicand 4 * (1 - x^2 - y^2); outside the disc the root is not used.
  logic [32:0] sum_sq;
  logic        inside_disc;
  logic [32:0] rad_diff;
  logic [32:0] radicand;
  assign sum_sq = {1'b0, q_sqx} + {1'b0, q_sqy};
  assign inside_disc = sum_sq < 33'h0_4000_0000;
  assign rad_diff = 33'h0_4000_0000 - sum_sq;
  assign radicand = inside_disc ? {rad_diff[30:0], 2'b00} : '0;

  logic        r_valid;
  logic [16:0] r_root;
  logic [32:0] r_meta;

  chs_sqrt #(.MW(33)) u_sqrt (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(q_valid),
    .radicand(radicand),
    .in_meta({q_ox, q_oy, inside_disc}),
    .out_valid(r_valid),
    .root(r_root),
    .out_meta(r_meta)
  );

  // z = (root + 1) / 2, saturated.
  logic [17:0] z_round;
  logic [14:0] z_c;
  assign z_round = {1'b0, r_root} + 18'd1;
  assign z_c = !r_meta[0] ? 15'd0 :
               (z_round[17:1] > 17'h07fff) ? 15'h7fff : z_round[15:1];

  logic        z_valid;
  logic [14:0] z_z;
  logic [15:0] z_ox, z_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_valid <= 1'b0;
    end else if (adv) begin
      z_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_z <= z_c;
      z_ox <= r_meta[32:17];
      z_oy <= r_meta[16:1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= z_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x <= z_ox;
      dir_y <= z_oy;
      dir_z <= z_z;
      density <= chs_pkg::div_pi16({z_z, 1'b0});
    end
  end

endmodule

// ----- hw/rtl/chs_div.sv -----
module chs_div #(
  parameter int DW = 17,
  parameter int MW = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [DW-1:0]                numer,
  input  logic [DW-1:0]                denom,
  input  logic [MW-1:0]                in_meta,
  output logic                         out_valid,
  output logic [chs_pkg::T_W-1:0]      quot,
  output logic [MW-1:0]                out_meta
);

  localparam int QW = chs_pkg::T_W;
  localparam int NW = DW + QW;

  // Rounded dividend numer * 2^30 + denom / 2; its top part is already below denom.
  logic [NW-1:0] dividend;
  assign dividend = {1'b0, numer, 30'd0} + {{(QW + 1){1'b0}}, denom[DW-1:1]};

  logic [DW-1:0] rem [0:QW-1];
  logic [QW-1:0] nlo [0:QW-1];
  logic [DW-1:0] dv [0:QW-1];
  logic [QW-1:0] q [0:QW];
  logic [MW-1:0] meta [0:QW];
  logic          vld [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= dividend[NW-1:QW];
      nlo[0] <= dividend[QW-1:0];
      dv[0] <= denom;
      q[0] <= '0;
      meta[0] <= in_meta;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;
    assign shifted = {rem[i], nlo[i][QW-1]};
    assign diff = shifted - {1'b0, dv[i]};
    assign ge = shifted >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q[i+1] <= {q[i][QW-2:0], ge};
        meta[i+1] <= meta[i];
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[i+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
          nlo[i+1] <= {nlo[i][QW-2:0], 1'b0};
          dv[i+1] <= dv[i];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot = q[QW];
  assign out_meta = meta[QW];

endmodule

// ----- hw/rtl/chs_sqrt.sv -----
module chs_sqrt #(
  parameter int MW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [32:0]   radicand,
  input  logic [MW-1:0] in_meta,
  output logic          out_valid,
  output logic [16:0]   root,
  output logic [MW-1:0] out_meta
);

  localparam int NS = chs_pkg::SQ_STEPS;
  localparam int W = chs_pkg::SQ_W;

  logic [W-1:0]  n [0:NS-1];
  logic [W-1:0]  res [0:NS];
  logic [MW-1:0] meta [0:NS];
  logic          vld [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n[0] <= {1'b0, radicand};
      res[0] <= '0;
      meta[0] <= in_meta;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - j));
    logic [W-1:0] trial;
    logic         ge;
    assign trial = res[j] + BIT;
    assign ge = n[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        res[j+1] <= ge ? ((res[j] >> 1) + BIT) : (res[j] >> 1);
        meta[j+1] <= meta[j];
      end
    end

    if (j < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          n[j+1] <= ge ? (n[j] - trial) : n[j];
        end
      end
    end
  end

  assign out_valid = vld[NS];
  assign root = res[NS][16:0];
  assign out_meta = meta[NS];

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [15:0] u1;
    logic [15:0] u2;
  } sample_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] z;
    logic [14:0] pdf;
    logic [14:0] er;
    logic [14:0] eg;
    logic [14:0] eb;
  } bounce_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = chs_pkg::REG_RED;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] rand_first = 0;
  logic [15:0] rand_second = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] dir_x, dir_y;
  logic [14:0] dir_z, density, energy_red, energy_green, energy_blue;

  cosine_hemisphere_sampler uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  sample_t pending[$];
  bounce_t expected_dirs[$];
  logic [15:0] albedo_r = 0, albedo_g = 0, albedo_b = 0;
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit in_taken = 0;
  int in_gap = 0, out_gap = 0;

  function automatic logic [14:0] over_pi(logic [63:0] v);
    logic [63:0] p;
    p = (v * 64'd1367130551 + (64'd1 << 31)) >> 32;
    return p[14:0];
  endfunction

  function automatic logic [63:0] m30(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] to_q15(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return 16'((65536 - mag) & 16'hffff);
    end
    if (mag > 32767) mag = 32767;
    return 16'(mag);
  endfunction

  function automatic bounce_t sample_bounce(sample_t s);
    bounce_t o;
    longint sx, sy, rs, q;
    logic [63:0] r, aq, t, t2, p, sn, cs, along, across, mx, my, ax, ay, sum, z;
    bit nx, ny, axx, aneg;
    sx = 2 * longint'(s.u1) - 65536;
    sy = 2 * longint'(s.u2) - 65536;
    mx = 0; my = 0; nx = 0; ny = 0;
    if (!(sx == 0 && sy == 0)) begin
      if (sx >= -sy) begin
        if (sx > sy) begin rs = sx; q = sy; axx = 1; aneg = 0; end
        else begin rs = sy; q = sx; axx = 0; aneg = 0; end
      end else begin
        if (sx <= sy) begin rs = -sx; q = sy; axx = 1; aneg = 1; end
        else begin rs = -sy; q = sx; axx = 0; aneg = 1; end
      end
      r = rs;
      aq = (q < 0) ? -q : q;
      t = ((aq << 30) + (r >> 1)) / r;
      if (t > (64'd1 << 30)) t = 64'd1 << 30;
      t2 = m30(t, t);
      p = 64'd2674041 - m30(t2, 64'd39273);
      p = 64'd86699835 - m30(t2, p);
      p = 64'd843314857 - m30(t2, p);
      sn = m30(t, p);
      p = 64'd350032 - m30(t2, 64'd3856);
      p = 64'd17023472 - m30(t2, p);
      p = 64'd331168970 - m30(t2, p);
      cs = (64'd1 << 30) - m30(t2, p);
      along = (r * cs + (64'd1 << 30)) >> 31;
      across = (r * sn + (64'd1 << 30)) >> 31;
      if (axx) begin mx = along; nx = aneg; my = across; ny = (q < 0); end
      else begin my = along; ny = aneg; mx = across; nx = (q < 0); end
    end
    o.x = to_q15(nx, mx);
    o.y = to_q15(ny, my);
    ax = o.x[15] ? 65536 - o.x : o.x;
    ay = o.y[15] ? 65536 - o.y : o.y;
    sum = ax * ax + ay * ay;
    z = 0;
    if (sum < (64'd1 << 30)) begin
      z = (root64(((64'd1 << 30) - sum) << 2) + 1) >> 1;
      if (z > 32767) z = 32767;
    end
    o.z = z[14:0];
    o.pdf = over_pi(z << 1);
    o.er = over_pi(64'(albedo_r));
    o.eg = over_pi(64'(albedo_g));
    o.eb = over_pi(64'(albedo_b));
    return o;
  endfunction

  // Driver: one item per accepted handshake, with random bursts of idling and of output stalls.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 8);
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        in_valid <= 1;
        rand_first <= pending[0].u1;
        rand_second <= pending[0].u2;
      end else begin
        in_valid <= 0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic check_field(string nm, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      expected_dirs.push_back(sample_bounce('{rand_first, rand_second}));
      void'(pending.pop_front());
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_dirs.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %0h", $time, dir_x);
      end else begin
        bounce_t e;
        e = expected_dirs.pop_front();
        check_field("dir_x", e.x, dir_x);
        check_field("dir_y", e.y, dir_y);
        check_field("dir_z", 16'(e.z), 16'(dir_z));
        check_field("density", 16'(e.pdf), 16'(density));
        check_field("energy_red", 16'(e.er), 16'(energy_red));
        check_field("energy_green", 16'(e.eg), 16'(energy_green));
        check_field("energy_blue", 16'(e.eb), 16'(energy_blue));
      end
    end
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_albedo(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == chs_pkg::REG_RED) albedo_r = v;
    else if (idx == chs_pkg::REG_GREEN) albedo_g = v;
    else if (idx == chs_pkg::REG_BLUE) albedo_b = v;
  endtask

  task automatic drain;
    while (pending.size() > 0 || in_valid || expected_dirs.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic add(logic [15:0] a, logic [15:0] b);
    pending.push_back('{a, b});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: add(16'(16'h8000 + $urandom_range(0, 8) - 4),
               16'(16'h8000 + $urandom_range(0, 8) - 4));
        1: add($urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom));
        2: begin
          logic [15:0] v;
          v = 16'($urandom);
          add(v, $urandom_range(0, 1) ? v : 16'(-v));
        end
        default: add(16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Corners, axes, diagonals and the disc center.
    add(16'h8000, 16'h8000);
    add(16'h0000, 16'h0000);
    add(16'hffff, 16'hffff);
    add(16'h0000, 16'hffff);
    add(16'hffff, 16'h0000);
    add(16'h8000, 16'h0000);
    add(16'h8000, 16'hffff);
    add(16'h0000, 16'h8000);
    add(16'hffff, 16'h8000);
    add(16'h8001, 16'h8000);
    add(16'h8000, 16'h7fff);
    add(16'hc000, 16'hc000);
    add(16'h4000, 16'hc000);
    add(16'h5555, 16'haaaa);
    add(16'haaaa, 16'h5555);
    add(16'h7fff, 16'h7fff);
    drain();
    write_albedo(chs_pkg::REG_RED, 16'hffff);
    write_albedo(chs_pkg::REG_GREEN, 16'h0001);
    write_albedo(chs_pkg::REG_BLUE, 16'h8000);
    write_albedo(2'd3, 16'h1234);
    add_random(350);
    drain();
    write_albedo(chs_pkg::REG_RED, 16'h0000);
    write_albedo(chs_pkg::REG_GREEN, 16'hffff);
    write_albedo(chs_pkg::REG_BLUE, 16'hffff);
    add_random(350);
    drain();
    write_albedo(chs_pkg::REG_RED, 16'($urandom));
    write_albedo(chs_pkg::REG_GREEN, 16'($urandom));
    write_albedo(chs_pkg::REG_BLUE, 16'h0000);
    add_random(350);
    drain();
    write_albedo(chs_pkg::REG_RED, 16'($urandom));
    write_albedo(chs_pkg::REG_GREEN, 16'($urandom));
    write_albedo(chs_pkg::REG_BLUE, 16'($urandom));
    add_random(250);
    drain();
    quiet = 1;
    add_random(150);
    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ----- cosine_hemisphere_sampler.f -----
hw/rtl/chs_pkg.sv
hw/rtl/chs_div.sv
hw/rtl/chs_sqrt.sv
hw/rtl/cosine_hemisphere_sampler.sv
verif/tb.sv
